FILE: src/edge_gradient_magnitude_3x3_core_macros.svh
// Assertion macros shared by the edge-gradient RTL.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef EDGE_GRADIENT_MAGNITUDE_3X3_CORE_MACROS_SVH
`define EDGE_GRADIENT_MAGNITUDE_3X3_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define EGM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edge gradient check failed");

// Consequent must hold in the cycle after the antecedent.
`define EGM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edge gradient check failed");

`else

`define EGM_ASSERT_IMP(label, clk, rst, ante, cons)
`define EGM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/egm_pkg.sv
package egm_pkg;

  // Geometry limits
  localparam int DEF_MAX_LINE_WIDTH = 4096;
  localparam int HEIGHT_CAP         = 4096;

  // Field and datapath widths
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 13;
  localparam int ROW_W  = $clog2(HEIGHT_CAP);
  localparam int GRAD_W = 10;
  localparam int SQ_W   = 2 * GRAD_W + 1;
  localparam int IDX_W  = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_KERNEL_SELECT = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;

  // Register reset values and clamp bounds
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [CFG_W-1:0] MIN_DIM          = 13'd3;
  localparam logic [CFG_W-1:0] HEIGHT_MAX       = CFG_W'(HEIGHT_CAP);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_HOLD
  } egm_state_t;

  typedef enum logic {
    KERNEL_SOBEL   = 1'b0,
    KERNEL_PREWITT = 1'b1
  } egm_kernel_t;

  // Effective (clamped) frame geometry and kernel choice
  typedef struct packed {
    egm_kernel_t      kernel;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } egm_geom_t;

  // Gradient magnitudes and flags of one window
  typedef struct packed {
    logic [GRAD_W-1:0] gx_mag;
    logic [GRAD_W-1:0] gy_mag;
    logic              interior;
    logic              last;
  } egm_grad_t;

endpackage

FILE: src/egm_pixel_if.sv
interface egm_pixel_if import egm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] grey_pixel;

  modport source (output valid, output grey_pixel, input ready);
  modport sink (input valid, input grey_pixel, output ready);
endinterface

FILE: src/egm_edge_if.sv
interface egm_edge_if import egm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_value;
  logic             interior_valid;
  logic             frame_end;

  modport source (output valid, output edge_value, output interior_valid, output frame_end,
                  input ready);
  modport sink (input valid, input edge_value, input interior_valid, input frame_end,
                output ready);
endinterface

FILE: src/egm_ram.sv
module egm_ram import egm_pkg::*; #(
  parameter int WIDTH = 2 * PIX_W,
  parameter int DEPTH = DEF_MAX_LINE_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/egm_window.sv
`include "edge_gradient_magnitude_3x3_core_macros.svh"

module egm_window import egm_pkg::*; #(
  parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  egm_geom_t        geom,
  input  logic             read_en,
  input  logic             accept,
  input  logic [PIX_W-1:0] pixel,
  output logic             hit,
  output logic             grad_new,
  output egm_grad_t        grad
);

  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] rd_addr;
  logic             rd_ok;
  logic [PIX_W-1:0] win_left [3];
  logic [PIX_W-1:0] win_mid [3];
  logic [PIX_W-1:0] win_right [3];

  logic [CMP_W-1:0] w_x;
  logic [CMP_W-1:0] c_inc;
  logic [CFG_W-1:0] r_tmp;
  logic [COL_W-1:0] c_cur;
  logic [ROW_W-1:0] r_cur;
  logic             ram_re;
  logic [2*PIX_W-1:0] rd_data;
  logic             interior;
  logic             last;
  logic             sobel;
  logic [GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;

  // Weighted sum of three pixels: outer taps weight one, center two for Sobel
  function automatic logic [GRAD_W-1:0] tap_sum(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] m,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic             dbl);
    logic [GRAD_W-1:0] mw;
    mw = dbl ? (GRAD_W'(m) << 1) : GRAD_W'(m);
    return GRAD_W'(a) + GRAD_W'(b) + mw;
  endfunction

  function automatic logic [GRAD_W-1:0] abs_diff(input logic [GRAD_W-1:0] a,
                                                  input logic [GRAD_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Normalize the position against the current geometry
  always_comb begin
    w_x = CMP_W'(geom.width);
    if (CMP_W'(col) >= w_x) begin
      c_cur = '0;
      r_tmp = CFG_W'(row) + CFG_W'(1);
    end else begin
      c_cur = col;
      r_tmp = CFG_W'(row);
    end
    r_cur = (r_tmp >= geom.height) ? '0 : r_tmp[ROW_W-1:0];
    c_inc = CMP_W'(c_cur) + CMP_W'(1);
  end

  // Line stores: upper row in the high byte, middle row in the low byte
  assign ram_re = read_en && !accept;

  egm_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_LINE_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (accept),
    .waddr(c_cur),
    .wdata({rd_data[PIX_W-1:0], pixel}),
    .re   (ram_re),
    .raddr(c_cur),
    .rdata(rd_data)
  );

  // Track which column the read data belongs to
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= ram_re;
    end
    rd_addr <= c_cur;
  end

  assign hit = rd_ok && (rd_addr == c_cur);

  // Form the window and the gradient halves
  always_comb begin
    win_right[0] = rd_data[2*PIX_W-1:PIX_W];
    win_right[1] = rd_data[PIX_W-1:0];
    win_right[2] = pixel;
    sobel        = (geom.kernel == KERNEL_SOBEL);
    gx_pos = tap_sum(win_right[0], win_right[1], win_right[2], sobel);
    gx_neg = tap_sum(win_left[0], win_left[1], win_left[2], sobel);
    gy_pos = tap_sum(win_left[2], win_mid[2], win_right[2], sobel);
    gy_neg = tap_sum(win_left[0], win_mid[0], win_right[0], sobel);
    interior = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
    last     = (CMP_W'(c_cur) == w_x - CMP_W'(1)) &&
               (CFG_W'(r_cur) == geom.height - CFG_W'(1));
  end

  // Advance counters and window, register the gradient
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      grad_new <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win_left[i] <= '0;
        win_mid[i]  <= '0;
      end
    end else begin
      grad_new <= accept;
      if (accept) begin
        if (c_inc >= w_x) begin
          col <= '0;
          row <= last ? '0 : r_cur + ROW_W'(1);
        end else begin
          col <= c_inc[COL_W-1:0];
          row <= r_cur;
        end
        for (int i = 0; i < 3; i++) begin
          win_left[i] <= win_mid[i];
          win_mid[i]  <= win_right[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grad.gx_mag   <= abs_diff(gx_pos, gx_neg);
      grad.gy_mag   <= abs_diff(gy_pos, gy_neg);
      grad.interior <= interior;
      grad.last     <= last;
    end
  end

  `EGM_ASSERT_IMP(a_accept_on_hit, clk, rst, accept, hit)

endmodule

FILE: src/egm_sqrt.sv
`include "edge_gradient_magnitude_3x3_core_macros.svh"

module egm_sqrt import egm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [GRAD_W-1:0] gx_mag,
  input  logic [GRAD_W-1:0] gy_mag,
  output logic              done,
  output logic [PIX_W-1:0]  root
);

  localparam int BIT_W = $clog2(PIX_W);

  logic [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [SQ_W-1:0]     sq_sum;
  logic [BIT_W-1:0]    bit_idx;
  logic                busy;
  logic [PIX_W-1:0]    trial;
  logic [2*PIX_W-1:0]  trial_sq;
  logic                fits;

  // Squares of the two magnitudes
  assign gx_sq = gx_mag * gx_mag;
  assign gy_sq = gy_mag * gy_mag;

  // One result bit per step; roots past the 8-bit range set every bit
  always_comb begin
    trial    = root | (PIX_W'(1) << bit_idx);
    trial_sq = trial * trial;
    fits     = SQ_W'(trial_sq) <= sq_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (bit_idx == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sq_sum  <= SQ_W'(gx_sq) + SQ_W'(gy_sq);
      root    <= '0;
      bit_idx <= BIT_W'(PIX_W - 1);
    end else if (busy) begin
      if (fits) begin
        root <= trial;
      end
      bit_idx <= bit_idx - BIT_W'(1);
    end
  end

  `EGM_ASSERT_IMP(a_start_when_free, clk, rst, start, !busy)
  `EGM_ASSERT_IMP(a_done_after_run, clk, rst, done, !busy && $past(busy))

endmodule

FILE: src/edge_gradient_magnitude_3x3_core.sv
// Path: an accepted pixel's gradients are registered in the window, the 8-step
// square-root unit runs on them, and the result is loaded into the output register.
// A new pixel is taken only after that load and the line-store read issued after each write.
// Reset (synchronous, active high): counters, window and handshake state clear;
// kernel Sobel, 640 x 480. Line stores need no clearing.
`include "edge_gradient_magnitude_3x3_core_macros.svh"

module edge_gradient_magnitude_3x3_core import egm_pkg::*; #(
  parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  egm_pixel_if.sink        pixels,
  egm_edge_if.source       edges
);

  egm_state_t       state, state_next;
  egm_kernel_t      kernel_select;
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  egm_geom_t        geom;
  logic             hit;
  logic             grad_new;
  egm_grad_t        grad;
  logic             sq_done;
  logic [PIX_W-1:0] root;
  logic             pixel_acc;
  logic             load_out;
  logic             out_valid;
  logic [PIX_W-1:0] out_edge;
  logic             out_interior;
  logic             out_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= KERNEL_SOBEL;
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL_SELECT: kernel_select <= egm_kernel_t'(cfg_data[0]);
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp geometry to the supported range
  always_comb begin
    geom.kernel = kernel_select;
    if (image_width < MIN_DIM) begin
      geom.width = MIN_DIM;
    end else if (int'(image_width) > MAX_LINE_WIDTH) begin
      geom.width = CFG_W'(MAX_LINE_WIDTH);
    end else begin
      geom.width = image_width;
    end
    if (image_height < MIN_DIM) begin
      geom.height = MIN_DIM;
    end else if (image_height > HEIGHT_MAX) begin
      geom.height = HEIGHT_MAX;
    end else begin
      geom.height = image_height;
    end
  end

  assign pixels.ready = (state == S_IDLE) && hit;
  assign pixel_acc    = pixels.valid && pixels.ready;

  egm_window #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .read_en (state == S_IDLE),
    .accept  (pixel_acc),
    .pixel   (pixels.grey_pixel),
    .hit     (hit),
    .grad_new(grad_new),
    .grad    (grad)
  );

  egm_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (grad_new),
    .gx_mag(grad.gx_mag),
    .gy_mag(grad.gy_mag),
    .done  (sq_done),
    .root  (root)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and output-register load
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (pixel_acc) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (sq_done) begin
          load_out   = !out_valid || edges.ready;
          state_next = load_out ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        load_out = !out_valid || edges.ready;
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (edges.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_edge     <= grad.interior ? root : '0;
      out_interior <= grad.interior;
      out_last     <= grad.last;
    end
  end

  assign edges.valid          = out_valid;
  assign edges.edge_value     = out_edge;
  assign edges.interior_valid = out_interior;
  assign edges.frame_end      = out_last;

  `EGM_ASSERT_NEXT(a_one_item_in_flight, clk, rst, pixel_acc, !pixels.ready)
  `EGM_ASSERT_IMP(a_border_zero, clk, rst, edges.valid && !edges.interior_valid, edges.edge_value == '0)

endmodule
